### hw/rtl/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
// No dependencies.
package dvrt_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [4:0] METRIC_UNREACHABLE = 5'd16;

  localparam logic CFG_ROUTE_TIMEOUT   = 1'b0;
  localparam logic CFG_GARBAGE_TIMEOUT = 1'b1;

  // one slot as it travels around the ring
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [4:0]  cost;
    logic [31:0] timer;
  } slot_t;

  // per-transaction command seen by the processing stage
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [4:0]  metric;
    logic [31:0] route_load;
    logic [31:0] garbage_load;
  } cmd_t;

endpackage

### hw/rtl/distance_vector_route_table_core.sv
// Distance-vector route table: TABLE_ENTRIES slots held in a ring of cells
// that rotates one slot per cycle, while a transaction is in progress, past a
// single processing stage. A transaction occupies the ring for one full
// rotation, and its result is then valid at the outputs. One item is worked
// on at a time: the next transaction is accepted no earlier than the cycle in
// which the result is taken, and a result that waits for the receiver holds
// off the input. Depends on dvrt_pkg, dvrt_cell,
// dvrt_proc.
module distance_vector_route_table_core #(
  parameter int TABLE_ENTRIES = 32,
  parameter int TIMER_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_entry_index,
  input  logic [31:0] in_ip_addr,
  input  logic [31:0] in_subnet_mask,
  input  logic [31:0] in_next_hop,
  input  logic [4:0]  in_metric,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [4:0]  out_result_index,
  output logic [31:0] out_out_ip,
  output logic [31:0] out_out_mask,
  output logic [31:0] out_out_next_hop,
  output logic [4:0]  out_out_metric,
  output logic [15:0] out_out_time_left,
  output logic        out_route_changed
);

  localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(TABLE_ENTRIES - 1);

  logic [15:0] route_to_r, garbage_to_r;
  dvrt_pkg::cmd_t cmd_r;
  logic [4:0]  idx_r;
  logic        busy_r, done_r, chg_r;
  logic [IDX_BITS-1:0] pos_r;
  logic [4:0]  hit_idx_r;
  dvrt_pkg::slot_t hit_slot_r;

  dvrt_pkg::slot_t ring [TABLE_ENTRIES];
  dvrt_pkg::slot_t head_out;
  logic hit, sel_hit, fin;

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_to_r   <= 16'd180;
      garbage_to_r <= 16'd120;
    end else if (cfg_we) begin
      if (cfg_index == dvrt_pkg::CFG_ROUTE_TIMEOUT) route_to_r <= cfg_wdata;
      else garbage_to_r <= cfg_wdata;
    end
  end

  // ring of cells; the head cell feeds the processing stage
  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      dvrt_cell #(.TIMER_BITS(TIMER_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(busy_r),
        .slot_in((g == TABLE_ENTRIES - 1) ? head_out : ring[(g + 1) % TABLE_ENTRIES]),
        .slot_out(ring[g])
      );
    end
  endgenerate

  assign sel_hit = (32'(idx_r) < TABLE_ENTRIES) && (32'(pos_r) == 32'(idx_r));

  dvrt_proc #(.TIMER_BITS(TIMER_BITS)) u_proc (
    .cmd(cmd_r), .sel_hit(sel_hit), .done(done_r),
    .slot_in(ring[0]), .slot_out(head_out), .hit(hit)
  );

  assign fin      = busy_r && (pos_r == LAST);
  assign in_ready = !busy_r && (!out_valid || out_ready);

  // sequence one transaction through a full rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
      pos_r     <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (busy_r) begin
        pos_r <= pos_r + 1'b1;
        if (fin) begin
          busy_r    <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  // capture command and first hit
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.op           <= in_op;
      cmd_r.addr         <= in_ip_addr;
      cmd_r.mask         <= in_subnet_mask;
      cmd_r.hop          <= in_next_hop;
      cmd_r.metric       <= in_metric;
      cmd_r.route_load   <= 32'(route_to_r);
      cmd_r.garbage_load <= 32'(garbage_to_r);
      idx_r              <= in_entry_index;
      done_r             <= 1'b0;
      chg_r              <= 1'b0;
    end else if (busy_r && hit) begin
      if (!done_r) begin
        hit_idx_r  <= 5'(pos_r);
        hit_slot_r <= ring[0];
      end
      done_r <= 1'b1;
      chg_r  <= 1'b1;
    end
  end

  // form the result from the sequencer's captures
  logic is_entry, is_idx;
  always_comb begin
    is_entry = (cmd_r.op == dvrt_pkg::OP_REMOVE) || (cmd_r.op == dvrt_pkg::OP_READ);
    is_idx   = is_entry || (cmd_r.op == dvrt_pkg::OP_ADD) ||
               (cmd_r.op == dvrt_pkg::OP_FIND);
    out_status        = (cmd_r.op == dvrt_pkg::OP_TICK) ? 1'b0 : !(is_idx && done_r);
    out_result_index  = (is_idx && done_r) ? hit_idx_r : 5'd0;
    out_out_ip        = (is_entry && done_r) ? hit_slot_r.addr : 32'd0;
    out_out_mask      = (is_entry && done_r) ? hit_slot_r.mask : 32'd0;
    out_out_next_hop  = (is_entry && done_r) ? hit_slot_r.hop : 32'd0;
    out_out_metric    = (is_entry && done_r) ? hit_slot_r.cost : 5'd0;
    out_out_time_left = (is_entry && done_r) ? hit_slot_r.timer[15:0] : 16'd0;
    out_route_changed = (cmd_r.op == dvrt_pkg::OP_TICK) && chg_r;
  end

endmodule

### hw/rtl/dvrt_cell.sv
// One storage cell of the route ring; holds a slot and passes it on each shift.
// Depends on dvrt_pkg.
module dvrt_cell #(
  parameter int TIMER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  dvrt_pkg::slot_t slot_in,
  output dvrt_pkg::slot_t slot_out
);

  dvrt_pkg::slot_t slot_r;

  // advance the ring; valid is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (shift) begin
      slot_r.valid <= slot_in.valid;
    end
    if (shift) begin
      slot_r.addr  <= slot_in.addr;
      slot_r.mask  <= slot_in.mask;
      slot_r.hop   <= slot_in.hop;
      slot_r.cost  <= slot_in.cost;
      slot_r.timer <= slot_in.timer & ((32'd1 << TIMER_BITS) - 32'd1);
    end
  end

  assign slot_out = slot_r;

endmodule

### hw/rtl/dvrt_proc.sv
// Head processing stage: applies the current operation to the slot leaving
// the ring before it re-enters. Depends on dvrt_pkg.
module dvrt_proc #(
  parameter int TIMER_BITS = 16
) (
  input  dvrt_pkg::cmd_t  cmd,
  input  logic            sel_hit,
  input  logic            done,
  input  dvrt_pkg::slot_t slot_in,
  output dvrt_pkg::slot_t slot_out,
  output logic            hit
);

  logic [31:0] dec;
  logic [31:0] tmask;

  assign tmask = (32'd1 << TIMER_BITS) - 32'd1;
  assign dec   = (slot_in.timer != 32'd0) ? slot_in.timer - 32'd1 : 32'd0;

  // modify the passing slot according to the operation
  always_comb begin
    slot_out = slot_in;
    hit      = 1'b0;
    unique case (cmd.op) inside
      dvrt_pkg::OP_ADD: begin
        if (!slot_in.valid && !done) begin
          hit            = 1'b1;
          slot_out.valid = 1'b1;
          slot_out.addr  = cmd.addr;
          slot_out.mask  = cmd.mask;
          slot_out.hop   = cmd.hop;
          slot_out.cost  = (cmd.metric > dvrt_pkg::METRIC_UNREACHABLE) ?
                           dvrt_pkg::METRIC_UNREACHABLE : cmd.metric;
          slot_out.timer = cmd.route_load & tmask;
        end
      end
      dvrt_pkg::OP_REMOVE, dvrt_pkg::OP_READ: begin
        if (sel_hit && slot_in.valid) begin
          hit = 1'b1;
          if (cmd.op == dvrt_pkg::OP_REMOVE) slot_out.valid = 1'b0;
        end
      end
      dvrt_pkg::OP_FIND: begin
        hit = slot_in.valid && !done && slot_in.addr == cmd.addr &&
              slot_in.mask == cmd.mask;
      end
      dvrt_pkg::OP_TICK: begin
        if (slot_in.valid) begin
          slot_out.timer = dec;
          if (dec == 32'd0) begin
            if (slot_in.cost == dvrt_pkg::METRIC_UNREACHABLE) begin
              slot_out.valid = 1'b0;
            end else begin
              hit            = 1'b1;
              slot_out.cost  = dvrt_pkg::METRIC_UNREACHABLE;
              slot_out.timer = cmd.garbage_load & tmask;
            end
          end
        end
      end
      default: hit = 1'b0;
    endcase
  end

endmodule

### dv/tb_distance_vector_route_table_core.sv
// Self-checking testbench for distance_vector_route_table_core: directed table
// then random route traffic, checked against an in-bench route table model.
// Depends on dvrt_pkg and the core RTL.
module tb_distance_vector_route_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [2:0] OP_BAD = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [4:0]  in_entry_index = '0;
  logic [31:0] in_ip_addr = '0;
  logic [31:0] in_subnet_mask = '0;
  logic [31:0] in_next_hop = '0;
  logic [4:0]  in_metric = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [4:0]  out_result_index;
  logic [31:0] out_out_ip;
  logic [31:0] out_out_mask;
  logic [31:0] out_out_next_hop;
  logic [4:0]  out_out_metric;
  logic [15:0] out_out_time_left;
  logic        out_route_changed;

  distance_vector_route_table_core dut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic        status;
    logic [4:0]  index;
    logic [31:0] ip;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [4:0]  metric;
    logic [15:0] time_left;
    logic        changed;
  } route_reply_t;

  typedef struct {
    logic [2:0]   op;
    logic [4:0]   idx;
    logic [31:0]  ip;
    logic [31:0]  mask;
    logic [31:0]  hop;
    logic [4:0]   metric;
    bit           typed;
    route_reply_t reply;
  } route_cmd_t;

  // table shadow
  bit          tbl_valid[SLOTS];
  logic [31:0] tbl_ip[SLOTS];
  logic [31:0] tbl_mask[SLOTS];
  logic [31:0] tbl_hop[SLOTS];
  logic [4:0]  tbl_cost[SLOTS];
  logic [15:0] tbl_timer[SLOTS];
  logic [15:0] route_life = 16'd180;
  logic [15:0] garbage_life = 16'd120;

  route_reply_t pending_replies[$];
  route_cmd_t   directed_rows[$];
  int mismatches = 0;
  int replies_seen = 0;
  int cycles = 0;
  int ticks_sent = 0;
  int changes_seen = 0;
  bit hold_off = 1'b0;

  function automatic route_reply_t apply_route_op(route_cmd_t c);
    route_reply_t r;
    logic [4:0] met;
    r = '0;
    r.status = 1'b1;
    case (c.op) inside
      dvrt_pkg::OP_ADD: begin
        met = (c.metric > dvrt_pkg::METRIC_UNREACHABLE) ?
              dvrt_pkg::METRIC_UNREACHABLE : c.metric;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_ip[i] = c.ip;
            tbl_mask[i] = c.mask;
            tbl_hop[i] = c.hop;
            tbl_cost[i] = met;
            tbl_timer[i] = route_life;
            r.status = 1'b0;
            r.index = i[4:0];
            break;
          end
        end
      end
      dvrt_pkg::OP_REMOVE, dvrt_pkg::OP_READ: begin
        if (tbl_valid[c.idx]) begin
          r.status = 1'b0;
          r.index = c.idx;
          r.ip = tbl_ip[c.idx];
          r.mask = tbl_mask[c.idx];
          r.hop = tbl_hop[c.idx];
          r.metric = tbl_cost[c.idx];
          r.time_left = tbl_timer[c.idx];
          if (c.op == dvrt_pkg::OP_REMOVE) tbl_valid[c.idx] = 1'b0;
        end
      end
      dvrt_pkg::OP_FIND: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_ip[i] == c.ip && tbl_mask[i] == c.mask) begin
            r.status = 1'b0;
            r.index = i[4:0];
            break;
          end
        end
      end
      dvrt_pkg::OP_TICK: begin
        r.status = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_timer[i] != 0) tbl_timer[i]--;
          if (tbl_timer[i] == 0) begin
            if (tbl_cost[i] == dvrt_pkg::METRIC_UNREACHABLE) begin
              tbl_valid[i] = 1'b0;
            end else begin
              tbl_cost[i] = dvrt_pkg::METRIC_UNREACHABLE;
              tbl_timer[i] = garbage_life;
              r.changed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dvrt_pkg::CFG_ROUTE_TIMEOUT) route_life = val;
    else garbage_life = val;
  endtask

  // offer one transaction and hold it until accepted; called at a falling edge
  task automatic send_route_op(route_cmd_t c);
    route_reply_t r;
    in_valid <= 1'b1;
    in_op <= c.op;
    in_entry_index <= c.idx;
    in_ip_addr <= c.ip;
    in_subnet_mask <= c.mask;
    in_next_hop <= c.hop;
    in_metric <= c.metric;
    do @(posedge clk); while (!in_ready);
    r = apply_route_op(c);
    if (c.typed && r !== c.reply) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch op %0d: table %h, row %h", c.op, r, c.reply);
    end
    pending_replies.push_back(r);
    if (c.op == dvrt_pkg::OP_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic route_cmd_t make_row(logic [2:0] op, logic [4:0] idx, logic [31:0] ip,
      logic [31:0] mask, logic [31:0] hop, logic [4:0] met);
    route_cmd_t c;
    c.op = op; c.idx = idx; c.ip = ip; c.mask = mask; c.hop = hop; c.metric = met;
    c.typed = 1'b0; c.reply = '0;
    return c;
  endfunction

  function automatic route_cmd_t typed_row(route_cmd_t c, route_reply_t r);
    c.typed = 1'b1;
    c.reply = r;
    return c;
  endfunction

  // random key drawn from a small pool so finds hit often
  function automatic route_cmd_t rand_cmd(int add_weight);
    route_cmd_t c;
    int pick;
    int key;
    pick = $urandom_range(0, 99);
    key = $urandom_range(0, 11);
    c = make_row(dvrt_pkg::OP_TICK, 5'($urandom), {8'd10, key[7:0], 16'h0},
                 {16'hFFFF, 16'h0}, 32'($urandom), 5'($urandom_range(0, 31)));
    if ($urandom_range(0, 9) == 0) begin
      c.ip = $urandom;
      c.mask = $urandom;
    end
    if (pick < add_weight) c.op = dvrt_pkg::OP_ADD;
    else if (pick < add_weight + 12) c.op = dvrt_pkg::OP_REMOVE;
    else if (pick < add_weight + 27) c.op = dvrt_pkg::OP_READ;
    else if (pick < add_weight + 42) c.op = dvrt_pkg::OP_FIND;
    else if (pick < 97) c.op = dvrt_pkg::OP_TICK;
    else c.op = 3'($urandom_range(5, 7));
    return c;
  endfunction

  // receiver: own stall pattern, long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) out_ready <= 1'b0;
      else if ((phase / 200) % 3 == 2) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    route_reply_t got;
    route_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_result_index, out_out_ip, out_out_mask, out_out_next_hop,
             out_out_metric, out_out_time_left, out_route_changed};
      replies_seen++;
      if (got.changed) changes_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("distance_vector_route_table_core test failed");
      $finish;
    end
  end

  initial begin
    route_reply_t r;
    int burst;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows: empty table, extremes, metric saturation
    r = '0; r.status = 1'b1;
    directed_rows.push_back(typed_row(make_row(dvrt_pkg::OP_READ, 5'd0, '0, '0, '0, '0), r));
    directed_rows.push_back(typed_row(make_row(dvrt_pkg::OP_REMOVE, 5'd31, '0, '0, '0, '0),
                                      r));
    directed_rows.push_back(typed_row(make_row(dvrt_pkg::OP_FIND, '0, '1, '1, '0, '0), r));
    directed_rows.push_back(typed_row(make_row(OP_BAD, '1, '1, '1, '1, '1), r));
    r = '0;
    directed_rows.push_back(typed_row(make_row(dvrt_pkg::OP_TICK, '0, '0, '0, '0, '0), r));
    directed_rows.push_back(typed_row(make_row(dvrt_pkg::OP_ADD, '0, '1, '1, '1, 5'd31), r));
    directed_rows.push_back(make_row(dvrt_pkg::OP_ADD, '1, '0, '0, '0, 5'd0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_ADD, '0, 32'h0A000000, 32'hFF000000,
                                     32'h1, 5'd16));
    directed_rows.push_back(make_row(dvrt_pkg::OP_ADD, '0, 32'h0A000000, 32'hFF000000,
                                     32'h2, 5'd1));
    directed_rows.push_back(make_row(dvrt_pkg::OP_FIND, '0, 32'h0A000000, 32'hFF000000,
                                     '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_READ, 5'd0, '0, '0, '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_READ, 5'd1, '0, '0, '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_TICK, '0, '0, '0, '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_REMOVE, 5'd2, '0, '0, '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_FIND, '0, 32'h0A000000, 32'hFF000000,
                                     '0, '0));
    directed_rows.push_back(make_row(dvrt_pkg::OP_READ, 5'd2, '0, '0, '0, '0));
    foreach (directed_rows[i]) send_route_op(directed_rows[i]);
    // fill the table to overflow
    for (int i = 0; i < SLOTS + 2; i++)
      send_route_op(make_row(dvrt_pkg::OP_ADD, '0, 32'($urandom), 32'($urandom),
                             32'($urandom), 5'($urandom_range(0, 15))));
    send_route_op(make_row(dvrt_pkg::OP_READ, 5'd31, '0, '0, '0, '0));
    // long receiver hold-off while input keeps coming
    hold_off = 1'b1;
    fork
      begin repeat (300) @(negedge clk); hold_off = 1'b0; end
      for (int i = 0; i < 6; i++) send_route_op(rand_cmd(20));
    join
    wait_drained();

    // clear table then short timers: expiry and garbage removal
    for (int i = 0; i < SLOTS; i++)
      send_route_op(make_row(dvrt_pkg::OP_REMOVE, i[4:0], '0, '0, '0, '0));
    wait_drained();
    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd1);
    write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'd0);
    send_route_op(make_row(dvrt_pkg::OP_ADD, '0, 32'h1, 32'h2, 32'h3, 5'd4));
    send_route_op(make_row(dvrt_pkg::OP_ADD, '0, 32'h5, 32'h6, 32'h7, 5'd16));
    repeat (3) send_route_op(make_row(dvrt_pkg::OP_TICK, '0, '0, '0, '0, '0));
    wait_drained();
    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd0);
    write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'hFFFF);
    send_route_op(make_row(dvrt_pkg::OP_ADD, '0, 32'h9, 32'h9, 32'h9, 5'd2));
    send_route_op(make_row(dvrt_pkg::OP_TICK, '0, '0, '0, '0, '0));
    send_route_op(make_row(dvrt_pkg::OP_READ, 5'd0, '0, '0, '0, '0));
    wait_drained();

    // random phases over several timer settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd3);
          write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'd2);
        end
        1: begin
          write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'hFFFF);
          write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'd1);
        end
        2: begin
          write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd1);
          write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'hFFFF);
        end
        default: begin
          write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'($urandom_range(1, 8)));
          write_reg(dvrt_pkg::CFG_GARBAGE_TIMEOUT, 16'($urandom_range(1, 8)));
        end
      endcase
      for (int n = 0; n < 195; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++, n++) send_route_op(rand_cmd(ph < 4 ? 35 : 25));
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
      end
      wait_drained();
    end

    $display("ran %0d results including %0d ticks (%0d flagged a route change)",
             replies_seen, ticks_sent, changes_seen);
    $display("covered full table, empty slots, metric saturation, timer extremes");
    if (mismatches == 0) begin
      $display("distance_vector_route_table_core test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("distance_vector_route_table_core test failed");
    end
    $finish;
  end
endmodule
